>>> hw/rtl/srb_pkg.sv
`timescale 1ns / 1ps
package srb_pkg;

   localparam int ADDR_FIELD_W  = 48;
   localparam int ROOT_COUNT_W  = 7;
   localparam int CSR_INDEX_W   = 2;

   typedef enum logic [2:0] {
      REQ_REGISTER   = 3'd0,
      REQ_DEREGISTER = 3'd1,
      REQ_CONTAINS   = 3'd2,
      REQ_COUNT      = 3'd3,
      REQ_TRACE      = 3'd4
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_UNMARKED = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STACK_BASE = 2'd0,
      CSR_GROWS_UP   = 2'd1
   } csr_reg_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_COUNT,
      BK_TRACE
   } bk_state_type;

   // classified request as it travels from front to back
   typedef struct packed {
      logic [2:0] op;
      logic       in_range;
   } item_type;

endpackage

>>> hw/rtl/srb_front.sv
`timescale 1ns / 1ps
module srb_front #(
   parameter int SLOTS     = 64,
   parameter int ADDR_BITS = 48
) (
   input  logic [2:0]                        req_type,
   input  logic [srb_pkg::ADDR_FIELD_W-1:0]  req_root_address,
   input  logic [ADDR_BITS-1:0]              base,
   input  logic                              grows_up,
   output srb_pkg::item_type                 item,
   output logic [$clog2(SLOTS)-1:0]          idx
);
   import srb_pkg::*;

   localparam int AW = ADDR_BITS;
   localparam int IW = $clog2(SLOTS);

   logic [AW+ADDR_FIELD_W-1:0] addr_wide;
   logic [AW-1:0]              addr;
   logic [AW-1:0]              minuend;
   logic [AW-1:0]              subtrahend;
   logic [AW:0]                diff;
   logic                       below_base;

   assign addr_wide  = {{AW{1'b0}}, req_root_address};
   assign addr       = addr_wide[AW-1:0];

   // distance counted in the growth direction, borrow flags a negative one
   assign minuend    = grows_up ? addr : base;
   assign subtrahend = grows_up ? base : addr;
   assign diff       = {1'b0, minuend} - {1'b0, subtrahend};
   assign below_base = diff[AW];

   assign item.op       = req_type;
   assign item.in_range = !below_base && (diff[AW-1:0] < AW'(SLOTS));
   assign idx           = diff[IW-1:0];

endmodule

>>> hw/rtl/srb_queue.sv
`timescale 1ns / 1ps
module srb_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   import srb_pkg::*;

   logic [WIDTH-1:0] entries_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       fill_ff;
   logic [1:0]       fill_in;

   assign full      = fill_ff == 2'd2;
   assign pop_valid = fill_ff != 2'd0;
   assign pop_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/srb_back.sv
`timescale 1ns / 1ps
module srb_back #(
   parameter int SLOTS     = 64,
   parameter int ADDR_BITS = 48
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  srb_pkg::item_type                  q_item,
   input  logic [$clog2(SLOTS)-1:0]           q_idx,
   output logic                               q_pop,
   input  logic [ADDR_BITS-1:0]               base,
   input  logic                               grows_up,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_found,
   output logic [srb_pkg::ROOT_COUNT_W-1:0]   rsp_root_count,
   output logic [srb_pkg::ADDR_FIELD_W-1:0]   rsp_trace_address,
   output logic                               rsp_trace_valid,
   output logic                               rsp_last
);
   import srb_pkg::*;

   localparam int AW = ADDR_BITS;
   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   bk_state_type      state_ff;
   bk_state_type      state_in;
   logic [SLOTS-1:0]  marks_ff;
   logic [SLOTS-1:0]  marks_in;
   logic [SLOTS-1:0]  work_ff;
   logic [SLOTS-1:0]  work_in;
   logic [SLOTS-1:0]  work_clr;
   logic [IW-1:0]     slot_ff;
   logic [IW-1:0]     slot_in;
   logic [CW-1:0]     cnt_ff;
   logic [CW-1:0]     cnt_in;
   logic [AW-1:0]     addr_ff;
   logic [AW-1:0]     addr_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   status_type        status_ff;
   logic              found_ff;
   logic [CW-1:0]     count_ff;
   logic [AW-1:0]     taddr_ff;
   logic              tvalid_ff;
   logic              last_ff;

   logic              res_load;
   status_type        res_status;
   logic              res_found;
   logic [CW-1:0]     res_cnt;
   logic [AW-1:0]     res_addr;
   logic              res_tvalid;
   logic              res_last;

   logic              out_free;
   logic              last_slot;
   logic              cur_mark;

   logic [CW+ROOT_COUNT_W-1:0] count_wide;
   logic [AW+ADDR_FIELD_W-1:0] taddr_wide;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_slot = slot_ff == IW'(SLOTS - 1);
   assign cur_mark  = work_ff[slot_ff];

   always_comb begin
      work_clr          = work_ff;
      work_clr[slot_ff] = 1'b0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && out_free) begin
               if (q_item.op == REQ_COUNT) begin
                  state_in = BK_COUNT;
               end else if (q_item.op == REQ_TRACE && marks_ff != '0) begin
                  state_in = BK_TRACE;
               end
            end
         end
         BK_COUNT: begin
            if (last_slot && out_free) begin
               state_in = BK_IDLE;
            end
         end
         BK_TRACE: begin
            if (cur_mark && out_free && work_clr == '0) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // datapath and result selection
   always_comb begin
      q_pop      = 1'b0;
      marks_in   = marks_ff;
      work_in    = work_ff;
      slot_in    = slot_ff;
      cnt_in     = cnt_ff;
      addr_in    = addr_ff;
      res_load   = 1'b0;
      res_status = ST_OK;
      res_found  = 1'b0;
      res_cnt    = '0;
      res_addr   = '0;
      res_tvalid = 1'b0;
      res_last   = 1'b1;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               case (q_item.op)
                  REQ_REGISTER: begin
                     res_load = 1'b1;
                     if (!q_item.in_range) begin
                        res_status = ST_RANGE;
                     end else begin
                        marks_in[q_idx] = 1'b1;
                     end
                  end
                  REQ_DEREGISTER: begin
                     res_load = 1'b1;
                     if (!q_item.in_range) begin
                        res_status = ST_RANGE;
                     end else if (!marks_ff[q_idx]) begin
                        res_status = ST_UNMARKED;
                     end else begin
                        marks_in[q_idx] = 1'b0;
                     end
                  end
                  REQ_CONTAINS: begin
                     res_load = 1'b1;
                     if (!q_item.in_range) begin
                        res_status = ST_RANGE;
                     end else begin
                        res_found = marks_ff[q_idx];
                     end
                  end
                  REQ_COUNT: begin
                     work_in = marks_ff;
                     slot_in = '0;
                     cnt_in  = '0;
                  end
                  REQ_TRACE: begin
                     work_in  = marks_ff;
                     slot_in  = '0;
                     addr_in  = base;
                     res_load = marks_ff == '0;
                  end
                  default: begin
                     res_load = 1'b1;
                  end
               endcase
            end
         end
         BK_COUNT: begin
            if (!last_slot) begin
               cnt_in  = cnt_ff + CW'(cur_mark);
               slot_in = slot_ff + IW'(1);
            end else if (out_free) begin
               res_load = 1'b1;
               res_cnt  = cnt_ff + CW'(cur_mark);
            end
         end
         BK_TRACE: begin
            if (!cur_mark || out_free) begin
               slot_in = slot_ff + IW'(1);
               addr_in = grows_up ? addr_ff + AW'(1) : addr_ff - AW'(1);
            end
            if (cur_mark && out_free) begin
               res_load   = 1'b1;
               res_addr   = addr_ff;
               res_tvalid = 1'b1;
               res_last   = work_clr == '0;
               work_in    = work_clr;
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = res_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         marks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         marks_ff     <= marks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      slot_ff <= slot_in;
      cnt_ff  <= cnt_in;
      addr_ff <= addr_in;
      if (res_load) begin
         status_ff <= res_status;
         found_ff  <= res_found;
         count_ff  <= res_cnt;
         taddr_ff  <= res_addr;
         tvalid_ff <= res_tvalid;
         last_ff   <= res_last;
      end
   end

   assign count_wide        = {{ROOT_COUNT_W{1'b0}}, count_ff};
   assign taddr_wide        = {{ADDR_FIELD_W{1'b0}}, taddr_ff};
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_found         = found_ff;
   assign rsp_root_count    = count_wide[ROOT_COUNT_W-1:0];
   assign rsp_trace_address = taddr_wide[ADDR_FIELD_W-1:0];
   assign rsp_trace_valid   = tvalid_ff;
   assign rsp_last          = last_ff;

endmodule

>>> hw/rtl/stack_root_bitmap.sv
`timescale 1ns / 1ps
// Stack root bitmap: one mark bit per handle-sized stack slot, cleared at reset. A request
// address maps to slot (address - stack_base) when grows_up is set, otherwise
// (stack_base - address); a negative distance or one of SLOTS or more returns status 1 and
// leaves the bitmap alone. Register, deregister and contains each give one result beat and
// run at one request per clock while the result channel is not stalled and no count or trace
// is running; a result passes through the front queue and then the result register. Count
// walks the bitmap one slot a clock, holding on the last slot while a result beat is held by
// rsp_stall. Trace also walks one slot a clock, pausing on a marked slot while a result beat
// is held by rsp_stall, and ends on the highest marked slot; an empty bitmap gives one beat
// with trace_valid low.
// Requests queue (two deep) behind a count or trace. Configuration must be written only while
// the block is idle; the block itself does not enforce this.
module stack_root_bitmap #(
   parameter int SLOTS     = 64,
   parameter int ADDR_BITS = 48
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_type,
   input  logic [srb_pkg::ADDR_FIELD_W-1:0]   req_root_address,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_found,
   output logic [srb_pkg::ROOT_COUNT_W-1:0]   rsp_root_count,
   output logic [srb_pkg::ADDR_FIELD_W-1:0]   rsp_trace_address,
   output logic                               rsp_trace_valid,
   output logic                               rsp_last,
   // register writes
   input  logic                               csr_wr_en,
   input  logic [srb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [srb_pkg::ADDR_FIELD_W-1:0]   csr_wdata
);
   import srb_pkg::*;

   localparam int AW = ADDR_BITS;
   localparam int IW = $clog2(SLOTS);
   localparam int IT = $bits(item_type);
   localparam int QW = IT + IW;

   logic [ADDR_FIELD_W-1:0]    stack_base_ff;
   logic                       grows_up_ff;
   logic [AW+ADDR_FIELD_W-1:0] base_wide;
   logic [AW-1:0]              base;

   item_type                   front_item;
   logic [IW-1:0]              front_idx;
   logic                       push;
   logic                       q_full;
   logic                       q_valid;
   logic                       q_pop;
   logic [QW-1:0]              q_data;
   item_type                   q_item;
   logic [IW-1:0]              q_idx;

   // config registers, out-of-list indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         stack_base_ff <= '0;
         grows_up_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STACK_BASE: stack_base_ff <= csr_wdata;
            CSR_GROWS_UP:   grows_up_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // base taken modulo the address space width
   assign base_wide = {{AW{1'b0}}, stack_base_ff};
   assign base      = base_wide[AW-1:0];

   // front: range check and slot index
   srb_front #(
      .SLOTS     (SLOTS),
      .ADDR_BITS (ADDR_BITS)
   ) u_front (
      .req_type         (req_type),
      .req_root_address (req_root_address),
      .base             (base),
      .grows_up         (grows_up_ff),
      .item             (front_item),
      .idx              (front_idx)
   );

   // accept while the queue has room
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   srb_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({front_item, front_idx}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   assign q_item = q_data[QW-1:IW];
   assign q_idx  = q_data[IW-1:0];

   // back: bitmap, walker and result register
   srb_back #(
      .SLOTS     (SLOTS),
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_idx             (q_idx),
      .q_pop             (q_pop),
      .base              (base),
      .grows_up          (grows_up_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_found         (rsp_found),
      .rsp_root_count    (rsp_root_count),
      .rsp_trace_address (rsp_trace_address),
      .rsp_trace_valid   (rsp_trace_valid),
      .rsp_last          (rsp_last)
   );

endmodule

>>> hw/rtl/srb_checker.sv
`timescale 1ns / 1ps
module srb_checker #(
   parameter int SLOTS = 64
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [2:0]                         req_type,
   input logic [srb_pkg::ADDR_FIELD_W-1:0]   req_root_address,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [1:0]                         rsp_status,
   input logic                               rsp_found,
   input logic [srb_pkg::ROOT_COUNT_W-1:0]   rsp_root_count,
   input logic [srb_pkg::ADDR_FIELD_W-1:0]   rsp_trace_address,
   input logic                               rsp_trace_valid,
   input logic                               rsp_last,
   input logic                               csr_wr_en,
   input logic [srb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input logic [srb_pkg::ADDR_FIELD_W-1:0]   csr_wdata
);
   import srb_pkg::*;

   // no result beat right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a held result beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found)
         && $stable(rsp_root_count) && $stable(rsp_trace_address)
         && $stable(rsp_trace_valid) && $stable(rsp_last))
      else $error("stalled result changed");

   // trace beats carry nothing but an address and the last flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trace_valid |-> rsp_status == ST_OK && !rsp_found
         && rsp_root_count == '0)
      else $error("trace beat with foreign fields");

   // a contains hit is a single ok beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_last && rsp_status == ST_OK && !rsp_trace_valid)
      else $error("found beat malformed");

   // count never exceeds the slot count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_root_count <= ROOT_COUNT_W'(SLOTS))
      else $error("root count out of range");

endmodule

bind stack_root_bitmap srb_checker #(.SLOTS(SLOTS)) u_srb_checker (.*);
